// File: src/mlqb_pkg.sv
// mlqb_pkg: shared constants and types of the linear queue bank.
// Operation and status codes, controller states, default sizes.
// No dependencies.
`timescale 1ns / 1ps

package mlqb_pkg;

  localparam int MaxQueuesDef  = 16;
  localparam int QueueDepthDef = 8;
  localparam int CountW        = 5;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_DISP = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PTR  = 3'b010,
    S_OUT  = 3'b100
  } state_e;

endpackage

// File: src/mlqb_in_if.sv
// mlqb_in_if: request channel of the linear queue bank.
// valid/ready handshake with op, queue index and value. No dependencies.
`timescale 1ns / 1ps

interface mlqb_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  op;
  logic        [3:0]  queue_index;
  logic signed [31:0] value;

  modport source (output valid, op, queue_index, value, input ready);
  modport sink   (input valid, op, queue_index, value, output ready);
endinterface

// File: src/mlqb_out_if.sv
// mlqb_out_if: result channel of the linear queue bank.
// valid/ready handshake with status, data and last. No dependencies.
`timescale 1ns / 1ps

interface mlqb_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic signed [31:0] data;
  logic               last;

  modport source (output valid, status, data, last, input ready);
  modport sink   (input valid, status, data, last, output ready);
endinterface

// File: src/multi_linear_queue_bank.sv
// multi_linear_queue_bank: bank of linear queues sharing one element memory.
// Depends on mlqb_pkg, mlqb_in_if and mlqb_out_if.
//
// One request is in flight at a time. A request is taken in the idle cycle;
// the next cycle reads the queue's head/fill entry from the pointer memory
// and settles enqueue, overflow, underflow, invalid and empty display.
// Dequeue and a non-empty display then read the element memory into a
// register for the output state; display delivers one element per cycle
// while the output is not stalled. Op 3 is dropped without a result.
// Output stalls hold the current state. Pointer entries read as zero until
// first written (per-queue valid flops), so no clearing pass is needed.
`timescale 1ns / 1ps

module multi_linear_queue_bank #(
  parameter int MAX_QUEUES  = mlqb_pkg::MaxQueuesDef,
  parameter int QUEUE_DEPTH = mlqb_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mlqb_pkg::CountW-1:0]   cfg_wdata_i,
  mlqb_in_if.sink                       in_i,
  mlqb_out_if.source                    out_o
);

  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = HW + 1;
  localparam int PW = HW + FW;
  localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int AW = $clog2(MAX_QUEUES * QUEUE_DEPTH);
  localparam int KW = ($clog2(MAX_QUEUES + 1) > mlqb_pkg::CountW) ?
                      $clog2(MAX_QUEUES + 1) : mlqb_pkg::CountW;

  // memories
  logic [PW-1:0] ptr_mem [MAX_QUEUES];
  logic [31:0]   dat_mem [MAX_QUEUES * QUEUE_DEPTH];
  logic [MAX_QUEUES-1:0] ptr_vld_q;

  logic          ptr_re, ptr_we;
  logic [QW-1:0] ptr_ra, ptr_wa;
  logic [PW-1:0] ptr_wd, ptr_rd_q;
  logic          dat_re, dat_we;
  logic [AW-1:0] dat_ra, dat_wa;
  logic [31:0]   dat_wd, dat_rd_q;

  logic [mlqb_pkg::CountW-1:0] queues_q;

  mlqb_pkg::state_e state_q, state_d;
  logic [1:0]    op_q;
  logic [3:0]    qn_q;
  logic [31:0]   val_q;
  logic [HW-1:0] idx_q, idx_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [AW-1:0] base_q, base_d;

  logic          out_valid_q;
  logic [2:0]    out_status_q;
  logic [31:0]   out_data_q;
  logic          out_last_q;

  logic          emit, emit_last;
  logic [2:0]    emit_status;
  logic [31:0]   emit_data;
  logic          out_free, in_xfer;

  logic [QW-1:0] qi;
  logic [HW-1:0] head_r;
  logic [FW-1:0] fill_r;
  logic          invalid, empty, idx_last;
  logic [CW-1:0] idx_nxt;
  logic [AW-1:0] base_r;

  assign in_i.ready   = (state_q == mlqb_pkg::S_IDLE);
  assign in_xfer      = in_i.valid && in_i.ready;
  assign out_free     = !out_valid_q || out_o.ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.data   = out_data_q;
  assign out_o.last   = out_last_q;

  assign qi      = QW'(qn_q);
  assign invalid = (KW'(qn_q) >= KW'(queues_q)) || (KW'(qn_q) >= KW'(MAX_QUEUES));
  assign head_r  = ptr_vld_q[qi] ? ptr_rd_q[PW-1:FW] : '0;
  assign fill_r  = ptr_vld_q[qi] ? ptr_rd_q[FW-1:0]  : '0;
  assign empty   = (fill_r == '0) || (CW'(head_r) >= CW'(fill_r));
  assign base_r  = AW'(qi) * AW'(QUEUE_DEPTH);
  assign idx_nxt = CW'(idx_q) + CW'(1);
  assign idx_last = (idx_nxt >= CW'(fill_q));

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    base_d      = base_q;
    ptr_re      = 1'b0;
    ptr_ra      = QW'(in_i.queue_index);
    ptr_we      = 1'b0;
    ptr_wa      = qi;
    ptr_wd      = '0;
    dat_re      = 1'b0;
    dat_ra      = base_q + AW'(idx_nxt);
    dat_we      = 1'b0;
    dat_wa      = base_r + AW'(fill_r);
    dat_wd      = val_q;
    emit        = 1'b0;
    emit_status = mlqb_pkg::ST_OK;
    emit_data   = '0;
    emit_last   = 1'b1;
    unique case (state_q)
      mlqb_pkg::S_IDLE: begin
        if (in_xfer && in_i.op != mlqb_pkg::OP_NONE) begin
          ptr_re  = 1'b1;
          state_d = mlqb_pkg::S_PTR;
        end
      end
      mlqb_pkg::S_PTR: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = mlqb_pkg::S_IDLE;
          if (invalid) begin
            emit_status = mlqb_pkg::ST_INVALID;
          end else if (op_q == mlqb_pkg::OP_ENQ) begin
            if (CW'(fill_r) >= CW'(QUEUE_DEPTH)) begin
              emit_status = mlqb_pkg::ST_OVERFLOW;
            end else begin
              dat_we = 1'b1;
              ptr_we = 1'b1;
              ptr_wd = {head_r, fill_r + FW'(1)};
            end
          end else if (empty) begin
            emit_status = (op_q == mlqb_pkg::OP_DEQ) ? mlqb_pkg::ST_UNDERFLOW
                                                     : mlqb_pkg::ST_EMPTY;
          end else begin
            emit    = 1'b0;
            dat_re  = 1'b1;
            dat_ra  = base_r + AW'(head_r);
            idx_d   = head_r;
            fill_d  = fill_r;
            base_d  = base_r;
            state_d = mlqb_pkg::S_OUT;
          end
        end
      end
      mlqb_pkg::S_OUT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = dat_rd_q;
          if (op_q == mlqb_pkg::OP_DEQ) begin
            ptr_we  = 1'b1;
            ptr_wd  = idx_last ? '0 : {HW'(idx_nxt), fill_q};
            state_d = mlqb_pkg::S_IDLE;
          end else begin
            emit_last = idx_last;
            if (idx_last) begin
              state_d = mlqb_pkg::S_IDLE;
            end else begin
              dat_re = 1'b1;
              idx_d  = HW'(idx_nxt);
            end
          end
        end
      end
      default: state_d = mlqb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ptr_we) begin
      ptr_mem[ptr_wa] <= ptr_wd;
    end
    if (ptr_re) begin
      ptr_rd_q <= ptr_mem[ptr_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dat_we) begin
      dat_mem[dat_wa] <= dat_wd;
    end
    if (dat_re) begin
      dat_rd_q <= dat_mem[dat_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlqb_pkg::S_IDLE;
      ptr_vld_q   <= '0;
      queues_q    <= mlqb_pkg::CountW'(16);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ptr_we) begin
        ptr_vld_q[ptr_wa] <= 1'b1;
      end
      if (cfg_we_i) begin
        queues_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= in_i.op;
      qn_q  <= in_i.queue_index;
      val_q <= in_i.value;
    end
    idx_q  <= idx_d;
    fill_q <= fill_d;
    base_q <= base_d;
    if (emit) begin
      out_status_q <= emit_status;
      out_data_q   <= emit_data;
      out_last_q   <= emit_last;
    end
  end

endmodule

// File: src/mlqb_checker.sv
// mlqb_checker: port-level assertions for multi_linear_queue_bank.
// Depends on mlqb_pkg; bound to the top level below.
`timescale 1ns / 1ps

module mlqb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_op_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_status_i,
  input logic [31:0] out_data_i,
  input logic        out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_data_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != mlqb_pkg::ST_OK |-> out_data_i == '0 && out_last_i)
    else $error("error result must be a single zero-data transfer");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i <= mlqb_pkg::ST_INVALID)
    else $error("undefined status code");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i != mlqb_pkg::OP_NONE |=> !in_ready_i)
    else $error("request taken while busy");

endmodule

bind multi_linear_queue_bank mlqb_checker u_mlqb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.op),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_data_i   (out_o.data),
  .out_last_i   (out_o.last)
);

// File: tb/testbench.sv
// testbench: self-checking bench for multi_linear_queue_bank.
// Directed table then random bursts, checked against a behavioural queue model.
// Depends on mlqb_pkg, mlqb_in_if, mlqb_out_if and the block itself.
`timescale 1ns / 1ps

module testbench;
  import mlqb_pkg::*;

  localparam int Depth     = QueueDepthDef;
  localparam int NumQueues = MaxQueuesDef;
  localparam int CycleCap  = 100000;
  localparam int NumRows   = 27;
  localparam int NumPhases = 8;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data;
    logic               last;
  } result_t;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  op;
    logic [3:0]  qi;
    logic [31:0] value;
    logic        fixed;
    logic [2:0]  st;
    logic [31:0] dat;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;

  mlqb_in_if  req_if ();
  mlqb_out_if rsp_if ();

  multi_linear_queue_bank dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (rsp_if)
  );

  // behavioural copy of the queue bank
  logic signed [31:0] model_store [NumQueues][Depth];
  logic [2:0]         model_head [NumQueues];
  logic [3:0]         model_fill [NumQueues];
  logic [CountW-1:0]  queue_count;

  result_t   item_results [$];
  result_t   pending_results [$];
  stim_row_t dir_rows [NumRows];

  int  failures;
  int  cycle_count;
  int  requests_sent;
  int  results_seen;
  int  cfg_writes;
  int  status_seen [8];
  int  stall_left;
  bit  quiet_tail;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleCap) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // result side stalls
  always @(negedge clk_i) begin
    if (!quiet_tail && stall_left == 0 && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 3);
    if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      status_seen[rsp_if.status]++;
      if (pending_results.size() == 0) begin
        if (failures < 10)
          $display("unexpected result: status %0d data %h last %b", rsp_if.status,
                   rsp_if.data, rsp_if.last);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status || rsp_if.data !== want.data ||
            rsp_if.last !== want.last) begin
          if (failures < 10)
            $display("mismatch: expected status %0d data %h last %b, got %0d %h %b",
                     want.status, want.data, want.last, rsp_if.status, rsp_if.data,
                     rsp_if.last);
          failures++;
        end
      end
    end
  end

  function automatic void add_result(logic [2:0] st, logic signed [31:0] dat, logic lst);
    result_t r;
    r.status = st;
    r.data   = dat;
    r.last   = lst;
    item_results.push_back(r);
  endfunction

  // works out the results of one request and updates the queue state
  function automatic void predict_queue_op(logic [1:0] op, logic [3:0] q,
                                           logic signed [31:0] val);
    int eff;
    int h;
    int f;
    int i;
    item_results.delete();
    if (op == OP_NONE) return;
    eff = (queue_count > NumQueues) ? NumQueues : int'(queue_count);
    if (int'(q) >= eff) begin
      add_result(ST_INVALID, 0, 1'b1);
      return;
    end
    h = model_head[q];
    f = model_fill[q];
    case (op)
      OP_ENQ: begin
        if (f >= Depth) begin
          add_result(ST_OVERFLOW, 0, 1'b1);
        end else begin
          model_store[q][f] = val;
          model_fill[q] = 4'(f + 1);
          add_result(ST_OK, 0, 1'b1);
        end
      end
      OP_DEQ: begin
        if (f == 0 || h >= f) begin
          add_result(ST_UNDERFLOW, 0, 1'b1);
        end else begin
          add_result(ST_OK, model_store[q][h], 1'b1);
          h++;
          if (h >= f) begin
            model_head[q] = '0;
            model_fill[q] = '0;
          end else begin
            model_head[q] = 3'(h);
          end
        end
      end
      default: begin
        if (f == 0 || h >= f) begin
          add_result(ST_EMPTY, 0, 1'b1);
        end else begin
          for (i = h; i < f; i++)
            add_result(ST_OK, model_store[q][i], (i + 1 == f));
        end
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] edges [4];
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
    if ($urandom_range(0, 9) == 0) return edges[$urandom_range(0, 3)];
    return $urandom();
  endfunction

  // one request transfer; fixed rows carry their own expected result
  task automatic drive_request(logic [1:0] op, logic [3:0] q, logic [31:0] val,
                               logic fixed, logic [2:0] st, logic [31:0] dat);
    int gap;
    result_t r;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.op          <= op;
    req_if.queue_index <= q;
    req_if.value       <= val;
    do @(posedge clk_i); while (!req_if.ready);
    predict_queue_op(op, q, val);
    if (op != OP_NONE) requests_sent++;
    if (fixed) begin
      r.status = st;
      r.data   = dat;
      r.last   = 1'b1;
      pending_results.push_back(r);
    end else begin
      foreach (item_results[i]) pending_results.push_back(item_results[i]);
    end
  endtask

  // register write once the block has gone quiet
  task automatic set_queue_count(logic [CountW-1:0] cnt);
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cnt;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    queue_count = cnt;
    cfg_writes++;
  endtask

  task automatic run_phase(logic [CountW-1:0] cnt, int quota);
    int done;
    int eff;
    int runlen;
    int pick;
    int k;
    logic [3:0] q;
    logic [1:0] op;
    done = 0;
    eff  = (cnt == 0) ? 1 : ((cnt > NumQueues) ? NumQueues : int'(cnt));
    while (done < quota) begin
      q    = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
                                           4'($urandom_range(0, eff - 1));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        runlen = $urandom_range(1, 9);
        op = OP_ENQ;
      end else if (pick < 80) begin
        runlen = $urandom_range(1, 9);
        op = OP_DEQ;
      end else if (pick < 93) begin
        runlen = 1;
        op = OP_DISP;
      end else if (pick < 97) begin
        runlen = 1;
        op = OP_NONE;
      end else begin
        runlen = 1;
        op = 2'($urandom_range(0, 3));
        q  = 4'($urandom_range(0, 15));
      end
      for (k = 0; k < runlen; k++) begin
        drive_request(op, q, pick_word(), 1'b0, ST_OK, '0);
        if (op != OP_NONE) done++;
      end
    end
  endtask

  initial begin
    logic [CountW-1:0] phase_cnt [NumPhases];
    int phase_quota [NumPhases];
    int p;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.op          = OP_NONE;
    req_if.queue_index = '0;
    req_if.value       = '0;
    rsp_if.ready       = 1'b0;
    queue_count        = 5'd16;
    foreach (model_head[i]) begin
      model_head[i] = '0;
      model_fill[i] = '0;
    end

    dir_rows = '{
      '{1'b0, OP_DISP, 4'd0,  32'h0,         1'b1, ST_EMPTY,     32'h0},
      '{1'b0, OP_DEQ,  4'd15, 32'h0,         1'b1, ST_UNDERFLOW, 32'h0},
      '{1'b0, OP_ENQ,  4'd0,  32'h8000_0000, 1'b1, ST_OK,        32'h0},
      '{1'b0, OP_ENQ,  4'd0,  32'h7fff_ffff, 1'b1, ST_OK,        32'h0},
      '{1'b0, OP_ENQ,  4'd0,  32'h0000_0000, 1'b0, ST_OK,        32'h0},
      '{1'b0, OP_ENQ,  4'd0,  32'hffff_ffff, 1'b0, ST_OK,        32'h0},
      '{1'b0, OP_DISP, 4'd0,  32'h0,         1'b0, ST_OK,        32'h0},
      '{1'b0, OP_DEQ,  4'd0,  32'h0,         1'b1, ST_OK,        32'h8000_0000},
      '{1'b0, OP_DEQ,  4'd0,  32'h0,         1'b1, ST_OK,        32'h7fff_ffff},
      '{1'b0, OP_ENQ,  4'd0,  32'haaaa_5555, 1'b0, ST_OK,        32'h0},
      '{1'b0, OP_ENQ,  4'd0,  32'h5555_aaaa, 1'b0, ST_OK,        32'h0},
      '{1'b0, OP_ENQ,  4'd0,  32'h1,         1'b0, ST_OK,        32'h0},
      '{1'b0, OP_ENQ,  4'd0,  32'h2,         1'b0, ST_OK,        32'h0},
      // tail at last slot with two freed slots in front: still overflows
      '{1'b0, OP_ENQ,  4'd0,  32'h3,         1'b1, ST_OVERFLOW,  32'h0},
      '{1'b0, OP_DISP, 4'd0,  32'h0,         1'b0, ST_OK,        32'h0},
      '{1'b0, OP_NONE, 4'd15, 32'hdead_beef, 1'b0, ST_OK,        32'h0},
      '{1'b0, OP_ENQ,  4'd15, 32'h1234_5678, 1'b1, ST_OK,        32'h0},
      '{1'b0, OP_DEQ,  4'd15, 32'h0,         1'b1, ST_OK,        32'h1234_5678},
      '{1'b0, OP_DEQ,  4'd15, 32'h0,         1'b1, ST_UNDERFLOW, 32'h0},
      '{1'b0, OP_DISP, 4'd15, 32'h0,         1'b1, ST_EMPTY,     32'h0},
      '{1'b1, OP_NONE, 4'd0,  32'd1,         1'b0, ST_OK,        32'h0},
      '{1'b0, OP_ENQ,  4'd1,  32'h0,         1'b1, ST_INVALID,   32'h0},
      '{1'b0, OP_DISP, 4'd0,  32'h0,         1'b0, ST_OK,        32'h0},
      '{1'b1, OP_NONE, 4'd0,  32'd0,         1'b0, ST_OK,        32'h0},
      '{1'b0, OP_DEQ,  4'd0,  32'h0,         1'b1, ST_INVALID,   32'h0},
      '{1'b1, OP_NONE, 4'd0,  32'd31,        1'b0, ST_OK,        32'h0},
      '{1'b0, OP_ENQ,  4'd15, 32'h0bad_cafe, 1'b0, ST_OK,        32'h0}
    };
    phase_cnt   = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd17, 5'($urandom_range(2, 15)), 5'd16};
    phase_quota = '{36, 30, 36, 36, 8, 36, 36, 36};

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        set_queue_count(dir_rows[i].value[CountW-1:0]);
      else
        drive_request(dir_rows[i].op, dir_rows[i].qi, dir_rows[i].value, dir_rows[i].fixed,
                      dir_rows[i].st, dir_rows[i].dat);
    end

    for (p = 0; p < NumPhases; p++) begin
      set_queue_count(phase_cnt[p]);
      if (p == NumPhases - 1) quiet_tail = 1'b1;
      run_phase(phase_cnt[p], phase_quota[p]);
    end

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d requests, %0d results, %0d register writes over %0d cycles",
             requests_sent, results_seen, cfg_writes, cycle_count);
    $display("status mix: ok %0d overflow %0d underflow %0d empty %0d invalid %0d",
             status_seen[ST_OK], status_seen[ST_OVERFLOW], status_seen[ST_UNDERFLOW],
             status_seen[ST_EMPTY], status_seen[ST_INVALID]);
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d failures", failures);
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/mlqb_pkg.sv
src/mlqb_in_if.sv
src/mlqb_out_if.sv
src/multi_linear_queue_bank.sv
src/mlqb_checker.sv
tb/testbench.sv
